[sv/crc16pf_pkg.sv]
// ----------------------------------------------------------------------------
// crc16pf_pkg - shared types and constants of the CRC-16 packet framer
// Request and response payload structs, request codes, register indexes
// and the CRC-16/MODBUS byte fold.
// ----------------------------------------------------------------------------
package crc16pf_pkg;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] seq_number;
        logic [7:0] value;
        logic [7:0] payload_length;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } rsp_t;

    // request codes
    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_END     = 3'd1;
    localparam logic [2:0] REQ_RETRY   = 3'd2;
    localparam logic [2:0] REQ_DATA    = 3'd3;
    localparam logic [2:0] REQ_PAYLOAD = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SYNC       = 3'd0;
    localparam logic [2:0] REG_START      = 3'd1;
    localparam logic [2:0] REG_END        = 3'd2;
    localparam logic [2:0] REG_TYPE_START = 3'd3;
    localparam logic [2:0] REG_TYPE_END   = 3'd4;
    localparam logic [2:0] REG_TYPE_NACK  = 3'd5;
    localparam logic [2:0] REG_TYPE_DATA  = 3'd6;
    localparam logic [2:0] REG_MAX_PAY    = 3'd7;

    localparam logic [7:0]  MAX_PAY_RESET = 8'd247;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // fold one byte into a CRC-16/MODBUS register, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[sv/crc16_packet_framer_core.sv]
// Output: the first byte of a request's packet passes the request register and then the
//   response register to rsp; the rest follow one per cycle while rsp_stall is low.
// Packet bytes: a payload request sends 1 byte (4 if it is the last), a start, end or
//   retry request 9, a data header 5 (8 at clamped length 0), an error 1.
// Reset: rst_n clears control state, the CRC to 0xFFFF, all header registers to 0
//   and max_payload to 247; no packet is open after reset.
// ----------------------------------------------------------------------------
// crc16_packet_framer_core - CRC-16/MODBUS packet framer
// Turns start, end, retry, data header and payload requests into a framed byte
// stream with sync/start header, CRC-16 trailer and end byte; misplaced requests give an error byte.
// ----------------------------------------------------------------------------
module crc16_packet_framer_core (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  crc16pf_pkg::req_t   req,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output crc16pf_pkg::rsp_t   rsp,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import crc16pf_pkg::*;

    // Emit slots: each accepted request walks a short slot sequence, one byte per slot.
    localparam logic [3:0] SLOT_H0   = 4'd0;   // sync byte
    localparam logic [3:0] SLOT_H1   = 4'd1;   // start byte
    localparam logic [3:0] SLOT_H2   = 4'd2;   // type byte
    localparam logic [3:0] SLOT_H3   = 4'd3;   // sequence byte
    localparam logic [3:0] SLOT_H4   = 4'd4;   // length byte
    localparam logic [3:0] SLOT_VOL  = 4'd5;   // volume byte of control packets
    localparam logic [3:0] SLOT_CRCH = 4'd6;
    localparam logic [3:0] SLOT_CRCL = 4'd7;
    localparam logic [3:0] SLOT_END  = 4'd8;
    localparam logic [3:0] SLOT_PAY  = 4'd9;   // payload echo
    localparam logic [3:0] SLOT_ERR  = 4'd10;  // misplaced request

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] sync_byte_reg;
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] type_start_reg;
    logic [7:0] type_end_reg;
    logic [7:0] type_nack_reg;
    logic [7:0] type_data_reg;
    logic [7:0] max_payload_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= '0;
            start_byte_reg  <= '0;
            end_byte_reg    <= '0;
            type_start_reg  <= '0;
            type_end_reg    <= '0;
            type_nack_reg   <= '0;
            type_data_reg   <= '0;
            max_payload_reg <= MAX_PAY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SYNC:       sync_byte_reg   <= pwdata[7:0];
                REG_START:      start_byte_reg  <= pwdata[7:0];
                REG_END:        end_byte_reg    <= pwdata[7:0];
                REG_TYPE_START: type_start_reg  <= pwdata[7:0];
                REG_TYPE_END:   type_end_reg    <= pwdata[7:0];
                REG_TYPE_NACK:  type_nack_reg   <= pwdata[7:0];
                REG_TYPE_DATA:  type_data_reg   <= pwdata[7:0];
                REG_MAX_PAY:    max_payload_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_SYNC:       prdata = {24'd0, sync_byte_reg};
            REG_START:      prdata = {24'd0, start_byte_reg};
            REG_END:        prdata = {24'd0, end_byte_reg};
            REG_TYPE_START: prdata = {24'd0, type_start_reg};
            REG_TYPE_END:   prdata = {24'd0, type_end_reg};
            REG_TYPE_NACK:  prdata = {24'd0, type_nack_reg};
            REG_TYPE_DATA:  prdata = {24'd0, type_data_reg};
            REG_MAX_PAY:    prdata = {24'd0, max_payload_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request register: the accepted request, already decoded into the
    // bytes it will send and the shape of its slot sequence.
    // ------------------------------------------------------------------
    logic       busy_reg,  busy_next;
    logic [3:0] slot_reg,  slot_next;
    logic       ctrl_reg,  ctrl_next;    // control packet: send volume after header
    logic       trail_reg, trail_next;   // send CRC and end after header or payload
    logic [7:0] type_reg,  type_next;
    logic [7:0] seq_reg,   seq_next;
    logic [7:0] len_reg,   len_next;
    logic [7:0] vol_reg,   vol_next;     // volume byte, or the payload byte

    // Packet state, updated as each request is taken in.
    logic       open_reg,   open_next;
    logic [7:0] remain_reg, remain_next;
    logic [15:0] crc_reg,   crc_next;

    // Response register
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg,       rsp_next;

    logic       req_accept;
    logic       emit;
    logic       slot_done;
    logic [7:0] clamp_len;
    logic       misplaced;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       emit_error;

    // An emit slot fires whenever the response register is free or draining.
    assign emit       = busy_reg && (!rsp_valid_reg || !rsp_stall);
    // Last slot of the held request: the next request may come in now.
    assign slot_done  = (slot_reg == SLOT_END) || (slot_reg == SLOT_ERR)
                     || ((slot_reg == SLOT_H4) && !ctrl_reg && !trail_reg)
                     || ((slot_reg == SLOT_PAY) && !trail_reg);
    assign req_stall  = busy_reg && !(emit && slot_done);
    assign req_accept = req_valid && !req_stall;

    assign clamp_len  = (req.payload_length > max_payload_reg) ? max_payload_reg
                                                                : req.payload_length;
    // Header and control requests are misplaced inside an open data packet,
    // payload bytes outside one, and unknown codes always.
    assign misplaced  = ((req.req_type <= REQ_DATA) && open_reg)
                     || ((req.req_type == REQ_PAYLOAD) && !open_reg)
                     || (req.req_type > REQ_PAYLOAD);

    // Decode the incoming request.
    always_comb
    begin
        busy_next   = busy_reg;
        slot_next   = slot_reg;
        ctrl_next   = ctrl_reg;
        trail_next  = trail_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        vol_next    = vol_reg;
        open_next   = open_reg;
        remain_next = remain_reg;

        // advance through the held request's slots
        if (emit)
        begin
            if (slot_done)
            begin
                busy_next = 1'b0;
            end
            else if ((slot_reg == SLOT_H4) && !ctrl_reg)
            begin
                slot_next = SLOT_CRCH;     // zero-length data: straight to trailer
            end
            else if (slot_reg == SLOT_PAY)
            begin
                slot_next = SLOT_CRCH;     // last payload byte closes the packet
            end
            else
            begin
                slot_next = slot_reg + 4'd1;
            end
        end

        if (req_accept)
        begin
            busy_next  = 1'b1;
            ctrl_next  = 1'b0;
            trail_next = 1'b0;
            seq_next   = 8'd0;
            len_next   = 8'd0;
            vol_next   = 8'd0;
            type_next  = 8'd0;
            if (misplaced)
            begin
                slot_next = SLOT_ERR;
            end
            else
            begin
                case (req.req_type)
                    REQ_START:
                    begin
                        slot_next  = SLOT_H0;
                        ctrl_next  = 1'b1;
                        trail_next = 1'b1;
                        type_next  = type_start_reg;
                        vol_next   = req.value;
                    end
                    REQ_END:
                    begin
                        slot_next  = SLOT_H0;
                        ctrl_next  = 1'b1;
                        trail_next = 1'b1;
                        type_next  = type_end_reg;
                        seq_next   = req.seq_number;
                    end
                    REQ_RETRY:
                    begin
                        slot_next  = SLOT_H0;
                        ctrl_next  = 1'b1;
                        trail_next = 1'b1;
                        type_next  = type_nack_reg;
                        vol_next   = req.seq_number;
                    end
                    REQ_DATA:
                    begin
                        slot_next  = SLOT_H0;
                        trail_next = (clamp_len == 8'd0);
                        type_next  = type_data_reg;
                        seq_next   = req.seq_number;
                        len_next   = clamp_len;
                        if (clamp_len != 8'd0)
                        begin
                            open_next   = 1'b1;
                            remain_next = clamp_len;
                        end
                    end
                    default:
                    begin
                        // payload byte inside an open packet
                        slot_next   = SLOT_PAY;
                        vol_next    = req.value;
                        trail_next  = (remain_reg == 8'd1);
                        remain_next = remain_reg - 8'd1;
                        if (remain_reg == 8'd1)
                        begin
                            open_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // Pick the byte of the current slot, fold header and payload bytes into the CRC and load the response register.
    always_comb
    begin
        emit_last  = 1'b0;
        emit_error = 1'b0;
        case (slot_reg)
            SLOT_H0:   emit_byte = sync_byte_reg;
            SLOT_H1:   emit_byte = start_byte_reg;
            SLOT_H2:   emit_byte = type_reg;
            SLOT_H3:   emit_byte = seq_reg;
            SLOT_H4:   emit_byte = len_reg;
            SLOT_VOL:  emit_byte = vol_reg;
            SLOT_CRCH: emit_byte = crc_reg[15:8];
            SLOT_CRCL: emit_byte = crc_reg[7:0];
            SLOT_END:
            begin
                emit_byte = end_byte_reg;
                emit_last = 1'b1;
            end
            SLOT_PAY:  emit_byte = vol_reg;
            SLOT_ERR:
            begin
                emit_byte  = 8'd0;
                emit_error = 1'b1;
            end
            default:   emit_byte = 8'd0;
        endcase

        crc_next = crc_reg;
        if (emit && (slot_reg inside {[SLOT_H0:SLOT_H4], SLOT_PAY}))
        begin
            // each header restarts the CRC; the volume byte is left out
            crc_next = crc_fold((slot_reg == SLOT_H0) ? CRC_INIT : crc_reg, emit_byte);
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next    = 1'b1;
            rsp_next.out_byte = emit_byte;
            rsp_next.last     = emit_last;
            rsp_next.error    = emit_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= SLOT_H0;
            ctrl_reg      <= 1'b0;
            trail_reg     <= 1'b0;
            open_reg      <= 1'b0;
            remain_reg    <= '0;
            crc_reg       <= CRC_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
            ctrl_reg      <= ctrl_next;
            trail_reg     <= trail_next;
            open_reg      <= open_next;
            remain_reg    <= remain_next;
            crc_reg       <= crc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
        vol_reg  <= vol_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sv/crc16pf_checker.sv]
// ----------------------------------------------------------------------------
// crc16pf_checker - port-level checks of the CRC-16 packet framer
// Watches the request, response and configuration ports over time.
// ----------------------------------------------------------------------------
module crc16pf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  crc16pf_pkg::req_t   req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  crc16pf_pkg::rsp_t   rsp,
    input  logic                pready
);
    import crc16pf_pkg::*;

    logic req_accept;
    logic unknown_code;

    assign req_accept   = req_valid && !req_stall;
    assign unknown_code = (req.req_type > REQ_PAYLOAD);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // drop the byte and never close a packet on an error response
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> !rsp.last && (rsp.out_byte == 8'd0))
        else $error("error response carries data or last");

    // every accepted request shows its first byte on the response port unless the response is stalled
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept ##1 !rsp_stall |=> rsp_valid)
        else $error("accepted request produced no response");

    // unknown request codes give an error response
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && unknown_code ##1 !rsp_stall |=> rsp_valid && rsp.error)
        else $error("unknown request code not flagged");

    // the configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind crc16_packet_framer_core crc16pf_checker u_crc16pf_checker (.*);
